FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip assertion failed");
// next-cycle implication
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/pip_pkg.sv
`default_nettype none

package pip_pkg;

    // table size and coordinate format
    localparam int MAX_EDGES  = 1024;
    localparam int COORD_BITS = 24;
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);
    localparam int ADDR_W     = $clog2(MAX_EDGES);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = 4 * COORD_BITS;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    // operation codes on the request channel
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic [CNT_W-1:0]             t_count;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_HORIZ = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command kinds after classification
    typedef enum logic [2:0] {
        K_NOP,
        K_CLEAR,
        K_ADD,
        K_HORIZ,
        K_QUERY
    } t_kind;

    // x0/y0 hold the edge start or the query point, x1/y1 the edge end
    typedef struct packed {
        t_kind  kind;
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/pip_in_if.sv
`default_nettype none

interface pip_in_if;
    import pip_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    t_coord               start_x;
    t_coord               start_y;
    t_coord               end_x;
    t_coord               end_y;
    t_coord               point_x;
    t_coord               point_y;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, point_x, point_y,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/pip_out_if.sv
`default_nettype none

interface pip_out_if;
    import pip_pkg::*;

    logic                valid;
    logic                ready;
    logic                inside_res;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    edges_held;

    modport source (
        output valid, inside_res, status, edges_held,
        input  ready
    );

    modport sink (
        input  valid, inside_res, status, edges_held,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/pip_ram.sv
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/pip_front.sv
`default_nettype none

module pip_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    pip_in_if.sink             i_req,
    output pip_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);
    import pip_pkg::*;

    // two-slot queue, pointers wrap naturally at this depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              w_cls;
    logic              w_push;
    logic              w_pop;

    // classify the incoming beat
    always_comb begin
        w_cls.kind = K_NOP;
        w_cls.x0   = i_req.start_x;
        w_cls.y0   = i_req.start_y;
        w_cls.x1   = i_req.end_x;
        w_cls.y1   = i_req.end_y;
        unique case (i_req.operation)
            OP_CLEAR: w_cls.kind = K_CLEAR;
            OP_ADD: begin
                w_cls.kind = (i_req.start_y == i_req.end_y) ? K_HORIZ : K_ADD;
            end
            OP_QUERY: begin
                w_cls.kind = K_QUERY;
                w_cls.x0   = i_req.point_x;
                w_cls.y0   = i_req.point_y;
            end
            default: w_cls.kind = K_NOP;
        endcase
    end

    assign i_req.ready = (r_count != QCNT_W'(QDEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_slot[r_rd_ptr];

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cls;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pip_back.sv
`default_nettype none

module pip_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pip_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    pip_out_if.source          o_rsp
);
    import pip_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state  r_state, n_state;
    t_count  r_total, n_total;
    t_coord  r_px, n_px;
    t_coord  r_py, n_py;
    t_count  r_rd_idx, n_rd_idx;
    logic    r_parity, n_parity;
    logic    r_out_valid, n_out_valid;
    logic    r_inside, n_inside;
    t_status r_status, n_status;
    t_count  r_held, n_held;

    logic              w_out_free;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [EDGE_W-1:0] w_rd_data;
    t_coord            w_sx, w_sy, w_ex, w_ey;
    logic              w_hit;

    // edge pipeline registers
    logic  r_v1, r_v2, r_v3;
    t_diff r_dpx, r_dd, r_dpy, r_dex;
    logic  r_cross2, r_dpos2;
    t_prod r_p1, r_p2;
    logic  r_cross3, r_dpos3;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_out_free;

    // edge table
    pip_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_total[ADDR_W-1:0]),
        .i_wr_data ({i_cmd.x0, i_cmd.y0, i_cmd.x1, i_cmd.y1}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_sx = w_rd_data[4*COORD_BITS-1:3*COORD_BITS];
    assign w_sy = w_rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign w_ex = w_rd_data[2*COORD_BITS-1:COORD_BITS];
    assign w_ey = w_rd_data[COORD_BITS-1:0];

    // crossing right of the point, sign of dy picks the compare direction
    assign w_hit = r_cross3 && (r_dpos3 ? (r_p1 < r_p2) : (r_p2 < r_p1));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_px        = r_px;
        n_py        = r_py;
        n_rd_idx    = r_rd_idx;
        n_parity    = r_parity;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_inside    = r_inside;
        n_status    = r_status;
        n_held      = r_held;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_inside    = 1'b0;
                    n_status    = ST_OK;
                    n_held      = r_total;
                    unique case (i_cmd.kind)
                        K_CLEAR: begin
                            n_total = '0;
                            n_held  = '0;
                        end
                        K_ADD: begin
                            if (r_total == CNT_W'(MAX_EDGES)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_total = r_total + CNT_W'(1);
                                n_held  = r_total + CNT_W'(1);
                            end
                        end
                        K_HORIZ: n_status = ST_HORIZ;
                        K_QUERY: begin
                            n_px     = i_cmd.x0;
                            n_py     = i_cmd.y0;
                            n_rd_idx = '0;
                            n_parity = 1'b0;
                            // empty table answers at once
                            if (r_total != '0) begin
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                n_state     = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_v3 && w_hit) begin
                    n_parity = !r_parity;
                end
                if (r_rd_idx != r_total) begin
                    w_rd_en  = 1'b1;
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end else if (!r_v1 && !r_v2 && !r_v3 && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_inside    = r_parity;
                    n_status    = ST_OK;
                    n_held      = r_total;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_parity    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_rd_idx    <= n_rd_idx;
            r_parity    <= n_parity;
        end
        r_px     <= n_px;
        r_py     <= n_py;
        r_inside <= n_inside;
        r_status <= n_status;
        r_held   <= n_held;
    end

    // edge pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // differences, then products
    always_ff @(posedge i_clk) begin
        r_dpx    <= t_diff'(r_px) - t_diff'(w_sx);
        r_dd     <= t_diff'(w_ey) - t_diff'(w_sy);
        r_dpy    <= t_diff'(r_py) - t_diff'(w_sy);
        r_dex    <= t_diff'(w_ex) - t_diff'(w_sx);
        r_cross2 <= (w_sy > r_py) != (w_ey > r_py);
        r_dpos2  <= w_ey > w_sy;
        r_p1     <= r_dpx * r_dd;
        r_p2     <= r_dpy * r_dex;
        r_cross3 <= r_cross2;
        r_dpos3  <= r_dpos2;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.inside_res = r_inside;
    assign o_rsp.status     = r_status;
    assign o_rsp.edges_held = r_held;

endmodule

`default_nettype wire

FILE: sv/point_in_polygon_even_odd.sv
// result path: clear, add, horizontal-edge and unused-op beats, and empty-table queries
//   are registered in the front queue, then in the back end's result register; a query
//   over N > 0 edges first streams them through read, difference and product registers
// throughput: other beats 1 per cycle unless the response stalls; a query holds
//   the back end for its scan, one edge per cycle from the table's single read port
// reset: synchronous active low, empties the table and the queue; table contents are kept
`default_nettype none
`include "assert_macros.svh"

module point_in_polygon_even_odd (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pip_in_if.sink    i_req,
    pip_out_if.source o_rsp
);
    import pip_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    // accept and classify
    pip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    // table update and edge scan
    pip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .o_rsp       (o_rsp)
    );

    // checks
    `PIP_ASSERT_IMPL(a_held_range, i_clk, i_rst_n, o_rsp.valid,
        o_rsp.edges_held <= CNT_W'(MAX_EDGES))
    `PIP_ASSERT_IMPL(a_full_at_max, i_clk, i_rst_n, o_rsp.valid && o_rsp.status == ST_FULL,
        o_rsp.edges_held == CNT_W'(MAX_EDGES) && !o_rsp.inside_res)
    `PIP_ASSERT_IMPL(a_status_no_inside, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.status != ST_OK, !o_rsp.inside_res)
    `PIP_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_cmd_valid && w_cmd_ready && w_cmd.kind == K_CLEAR,
        o_rsp.valid && o_rsp.edges_held == '0)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pip_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 580;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_POLY      = 16;
    localparam int HELD_SOFT_CAP = 120;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // vertex placement styles for generated polygons
    localparam int SHAPE_SCATTER = 0;
    localparam int SHAPE_LATTICE = 1;
    localparam int SHAPE_EXTREME = 2;

    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef struct {
        logic [OP_W-1:0] op;
        t_coord          sx;
        t_coord          sy;
        t_coord          ex;
        t_coord          ey;
        t_coord          px;
        t_coord          py;
    } t_edge_req;

    typedef struct {
        logic    in_poly;
        t_status status;
        t_count  held;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pip_in_if  req_if ();
    pip_out_if rsp_if ();

    point_in_polygon_even_odd DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // stimulus and expected answers
    t_edge_req requests_pending[$];
    t_answer   answers_due[$];

    // shadow copy of the edge table
    t_coord tbl_sx[MAX_EDGES];
    t_coord tbl_sy[MAX_EDGES];
    t_coord tbl_ex[MAX_EDGES];
    t_coord tbl_ey[MAX_EDGES];
    int     held_count = 0;

    int        items_made   = 0;
    int        gen_held     = 0;
    int        results_seen = 0;
    int        fails        = 0;
    int        cycle_count  = 0;
    t_edge_req beat_on_bus;
    int        src_hold     = 0;
    bit        src_calm     = 1'b0;
    int        sink_hold    = 0;
    bit        sink_calm    = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    function automatic t_coord extreme_coord();
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return t_coord'(0);
            default: return t_coord'(-1);
        endcase
    endfunction

    // apply one beat to the shadow table and work out its answer
    function automatic t_answer step_edge_table(t_edge_req r);
        t_answer a;
        longint  px, py, sx, sy, ex, ey, d;
        bit      right;
        a.in_poly = 1'b0;
        a.status  = ST_OK;
        case (r.op)
            OP_CLEAR: held_count = 0;
            OP_ADD: begin
                if (r.sy == r.ey) begin
                    a.status = ST_HORIZ;
                end else if (held_count >= MAX_EDGES) begin
                    a.status = ST_FULL;
                end else begin
                    tbl_sx[held_count] = r.sx;
                    tbl_sy[held_count] = r.sy;
                    tbl_ex[held_count] = r.ex;
                    tbl_ey[held_count] = r.ey;
                    held_count++;
                end
            end
            OP_QUERY: begin
                px = r.px;
                py = r.py;
                for (int i = 0; i < held_count; i++) begin
                    sx = tbl_sx[i];
                    sy = tbl_sy[i];
                    ex = tbl_ex[i];
                    ey = tbl_ey[i];
                    // only edges whose y span straddles the scanline
                    if ((sy > py) != (ey > py)) begin
                        d = ey - sy;
                        // crossing strictly right of the point, no division
                        if (d > 0)
                            right = (px - sx) * d < (py - sy) * (ex - sx);
                        else
                            right = (py - sy) * (ex - sx) < (px - sx) * d;
                        if (right)
                            a.in_poly = ~a.in_poly;
                    end
                end
            end
            default: ;
        endcase
        a.held = t_count'(held_count);
        return a;
    endfunction

    task automatic push_beat(logic [OP_W-1:0] op, t_coord sx, t_coord sy, t_coord ex,
                             t_coord ey, t_coord px, t_coord py);
        t_edge_req r;
        r = '{op: op, sx: sx, sy: sy, ex: ex, ey: ey, px: px, py: py};
        requests_pending = {requests_pending, r};
        items_made++;
        if (op == OP_CLEAR)
            gen_held = 0;
        else if (op == OP_ADD && sy != ey && gen_held < MAX_EDGES)
            gen_held++;
    endtask

    task automatic add_edge(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        push_beat(OP_ADD, sx, sy, ex, ey, rand_coord(), rand_coord());
    endtask

    task automatic ask_point(t_coord px, t_coord py);
        push_beat(OP_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord(), px, py);
    endtask

    task automatic push_plain(logic [OP_W-1:0] op);
        push_beat(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
    endtask

    // one polygon (or open chain) followed by queries around it
    task automatic polygon_run(int nv, int spread, int shape, bit closed);
        t_coord vx[MAX_POLY];
        t_coord vy[MAX_POLY];
        int     cx, cy, step, j, jn, nq;
        cx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        cy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        step = (spread / 4 > 0) ? spread / 4 : 1;
        for (int i = 0; i < nv; i++) begin
            case (shape)
                SHAPE_LATTICE: begin
                    vx[i] = t_coord'(cx + step * (int'($urandom_range(0, 8)) - 4));
                    vy[i] = t_coord'(cy + step * (int'($urandom_range(0, 8)) - 4));
                end
                SHAPE_EXTREME: begin
                    vx[i] = extreme_coord();
                    vy[i] = extreme_coord();
                end
                default: begin
                    vx[i] = t_coord'(cx + int'($urandom_range(0, 2 * spread)) - spread);
                    vy[i] = t_coord'(cy + int'($urandom_range(0, 2 * spread)) - spread);
                end
            endcase
        end
        for (int i = 0; i < (closed ? nv : nv - 1); i++)
            add_edge(vx[i], vy[i], vx[(i + 1) % nv], vy[(i + 1) % nv]);
        nq = $urandom_range(2, 6);
        for (int k = 0; k < nq; k++) begin
            j = $urandom_range(0, nv - 1);
            jn = (j + 1) % nv;
            case ($urandom_range(0, 5))
                // exactly on a vertex
                2: ask_point(vx[j], vy[j]);
                // midpoint of an edge, on the edge for lattice shapes
                3: ask_point(t_coord'((int'(vx[j]) + int'(vx[jn])) >>> 1),
                             t_coord'((int'(vy[j]) + int'(vy[jn])) >>> 1));
                // scanline through a vertex
                4: ask_point(t_coord'(cx + int'($urandom_range(0, 3 * spread)) - 3 * spread / 2),
                             vy[j]);
                5: ask_point(shape == SHAPE_EXTREME ? extreme_coord() : rand_coord(),
                             shape == SHAPE_EXTREME ? extreme_coord() : rand_coord());
                default: ask_point(
                    t_coord'(cx + int'($urandom_range(0, 3 * spread)) - 3 * spread / 2),
                    t_coord'(cy + int'($urandom_range(0, 3 * spread)) - 3 * spread / 2));
            endcase
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid)
                answers_due = {answers_due, step_edge_table(beat_on_bus)};
            if (src_hold > 0) begin
                src_hold--;
                req_if.valid <= 1'b0;
            end else if (requests_pending.size() != 0) begin
                beat_on_bus = requests_pending.pop_front();
                req_if.valid     <= 1'b1;
                req_if.operation <= beat_on_bus.op;
                req_if.start_x   <= beat_on_bus.sx;
                req_if.start_y   <= beat_on_bus.sy;
                req_if.end_x     <= beat_on_bus.ex;
                req_if.end_y     <= beat_on_bus.ey;
                req_if.point_x   <= beat_on_bus.px;
                req_if.point_y   <= beat_on_bus.py;
                if ($urandom_range(0, 39) == 0)
                    src_calm = !src_calm;
                src_hold = draw_wait(src_calm);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge i_clk) begin
        t_answer due;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    $error("response beat with no answer pending");
                    fails++;
                end else begin
                    due = answers_due.pop_front();
                    if (rsp_if.inside_res !== due.in_poly) begin
                        $error("inside_res expected %0d actual %0d", due.in_poly,
                               rsp_if.inside_res);
                        fails++;
                    end
                    if (rsp_if.status !== due.status) begin
                        $error("status expected %0d actual %0d", due.status, rsp_if.status);
                        fails++;
                    end
                    if (rsp_if.edges_held !== due.held) begin
                        $error("edges_held expected %0d actual %0d", due.held,
                               rsp_if.edges_held);
                        fails++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_hold = draw_wait(sink_calm);
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            rsp_if.ready <= (sink_hold == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int  rand_base, fill_start, spread, kind, n;
        bit  filled;
        logic [OP_W-1:0] op;
        t_coord ny;
        filled = 1'b0;

        req_if.valid     = 1'b0;
        req_if.operation = OP_CLEAR;
        req_if.start_x   = '0;
        req_if.start_y   = '0;
        req_if.end_x     = '0;
        req_if.end_y     = '0;
        req_if.point_x   = '0;
        req_if.point_y   = '0;
        rsp_if.ready     = 1'b0;

        // directed: empty table, unused op, square with horizontal sides
        ask_point(t_coord'(0), t_coord'(0));
        push_plain(OP_UNUSED);
        add_edge(t_coord'(-1024), t_coord'(-1024), t_coord'(1024), t_coord'(-1024));
        add_edge(t_coord'(1024), t_coord'(-1024), t_coord'(1024), t_coord'(1024));
        add_edge(t_coord'(1024), t_coord'(1024), t_coord'(-1024), t_coord'(1024));
        add_edge(t_coord'(-1024), t_coord'(1024), t_coord'(-1024), t_coord'(-1024));
        ask_point(t_coord'(0), t_coord'(0));
        ask_point(t_coord'(2000), t_coord'(0));
        ask_point(t_coord'(-1024), t_coord'(0));
        ask_point(t_coord'(1024), t_coord'(0));
        ask_point(t_coord'(0), t_coord'(1024));
        ask_point(t_coord'(0), t_coord'(-1024));
        ask_point(t_coord'(-1024), t_coord'(-1024));
        // full-range diagonals stress the widest products
        add_edge(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        add_edge(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        ask_point(COORD_MAX, COORD_MAX);
        ask_point(COORD_MIN, COORD_MIN);
        ask_point(t_coord'(0), t_coord'(0));
        ask_point(COORD_MIN, t_coord'(0));
        ask_point(COORD_MIN, t_coord'(COORD_MAX - 1));
        add_edge(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
        push_plain(OP_CLEAR);
        ask_point(t_coord'(0), t_coord'(0));
        push_plain(OP_UNUSED);

        // random polygons, noise and one fill to capacity
        rand_base = items_made;
        while (items_made - rand_base < RANDOM_ITEMS) begin
            if (!filled && items_made - rand_base >= 250) begin
                filled = 1'b1;
                fill_start = items_made;
                push_plain(OP_CLEAR);
                while (gen_held < MAX_EDGES)
                    add_edge(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                add_edge(rand_coord(), t_coord'(5), rand_coord(), t_coord'(-5));
                ny = rand_coord();
                add_edge(rand_coord(), ny, rand_coord(), ny);
                ask_point(t_coord'(0), t_coord'(0));
                ask_point(rand_coord(), rand_coord());
                push_plain(OP_UNUSED);
                push_plain(OP_CLEAR);
                rand_base += items_made - fill_start;
            end
            kind = $urandom_range(0, 9);
            spread = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1 << 16, 1 << 22))
                                                 : int'($urandom_range(64, 4096));
            if (kind <= 7 && ($urandom_range(0, 3) != 0 || gen_held > HELD_SOFT_CAP))
                push_plain(OP_CLEAR);
            case (kind)
                6: polygon_run($urandom_range(3, 5), 1 << 22, SHAPE_EXTREME, 1'b1);
                7: polygon_run($urandom_range(3, 8), spread, SHAPE_LATTICE, 1'b0);
                8, 9: begin
                    n = $urandom_range(3, 8);
                    for (int i = 0; i < n; i++) begin
                        op = OP_W'($urandom_range(0, 3));
                        ny = rand_coord();
                        if (op == OP_ADD && $urandom_range(0, 3) == 0)
                            push_beat(op, rand_coord(), ny, rand_coord(), ny,
                                      rand_coord(), rand_coord());
                        else
                            push_beat(op, rand_coord(), ny, rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord());
                    end
                end
                default: polygon_run($urandom_range(3, MAX_POLY - 4), spread,
                                     kind[0] ? SHAPE_LATTICE : SHAPE_SCATTER, 1'b1);
            endcase
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (results_seen < items_made || answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
